### rtl/core/assert_macros.svh
// Assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/mtf_pkg.sv
`default_nettype none

package mtf_pkg;

  localparam int SYM_W         = 8;
  localparam int ALPHABET_MAX  = 256;
  localparam int GROUP_SIZE    = 16;

  typedef logic [SYM_W-1:0] sym_t;

  // Per-cycle controls broadcast to every cell in the list
  typedef struct packed {
    logic restore;  // reload identity order
    logic commit;   // apply move-to-front this cycle
    logic decode;   // match on position instead of symbol
    sym_t key;      // symbol or position to look up
    sym_t pos;      // position being promoted
    sym_t front;    // symbol that lands in position zero
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/mtf_cell.sv
`default_nettype none

module mtf_cell #(
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mtf_pkg::cell_ctrl_t ctrl,
  input  wire mtf_pkg::sym_t      left_sym,
  output mtf_pkg::sym_t           sym,
  output logic                    hit
);
  import mtf_pkg::*;

  localparam sym_t MY_POS = SYM_W'(IDX);

  sym_t sym_r;
  sym_t sym_nxt;

  // Match on the held symbol (encode) or on this cell's position (decode)
  assign hit = ctrl.decode ? (MY_POS == ctrl.key) : (sym_r == ctrl.key);
  assign sym = sym_r;

  // Restore to identity, or take the neighbor's symbol when at or before the promoted slot
  always_comb begin
    sym_nxt = sym_r;
    if (ctrl.restore) begin
      sym_nxt = MY_POS;
    end else if (ctrl.commit && (MY_POS <= ctrl.pos)) begin
      sym_nxt = left_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r <= MY_POS;
    end else begin
      sym_r <= sym_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mtf_reduce.sv
`default_nettype none

module mtf_reduce #(
  parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_MAX
) (
  input  wire logic                     clk,
  input  wire logic [ALPHABET_SIZE-1:0] hit,
  input  wire mtf_pkg::sym_t            sym [ALPHABET_SIZE],
  output mtf_pkg::sym_t                 pos,
  output mtf_pkg::sym_t                 found
);
  import mtf_pkg::*;

  localparam int NUM_GROUPS = (ALPHABET_SIZE + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PAD_SIZE   = NUM_GROUPS * GROUP_SIZE;

  logic [PAD_SIZE-1:0] hit_pad;
  sym_t                sym_pad [PAD_SIZE];
  sym_t                grp_pos_nxt [NUM_GROUPS];
  sym_t                grp_sym_nxt [NUM_GROUPS];
  sym_t                grp_pos_r   [NUM_GROUPS];
  sym_t                grp_sym_r   [NUM_GROUPS];

  // Pad the last group with empty slots
  always_comb begin
    hit_pad = '0;
    hit_pad[ALPHABET_SIZE-1:0] = hit;
    for (int i = 0; i < PAD_SIZE; i++) begin
      sym_pad[i] = (i < ALPHABET_SIZE) ? sym[i] : '0;
    end
  end

  // First level: one-hot OR inside each group, registered
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_pos_nxt[g] = '0;
      grp_sym_nxt[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (hit_pad[g*GROUP_SIZE + j]) begin
          grp_pos_nxt[g] = grp_pos_nxt[g] | SYM_W'(g*GROUP_SIZE + j);
          grp_sym_nxt[g] = grp_sym_nxt[g] | sym_pad[g*GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_pos_r[g] <= grp_pos_nxt[g];
      grp_sym_r[g] <= grp_sym_nxt[g];
    end
  end

  // Second level: OR across groups
  always_comb begin
    pos   = '0;
    found = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      pos   = pos | grp_pos_r[g];
      found = found | grp_sym_r[g];
    end
  end

endmodule

`default_nettype wire

### rtl/core/move_to_front_byte_coder.sv
// Transform request: accepted in idle, passes through match and update, and its result is
// registered from update. Requests are taken only in idle, a pace bounded by the
// registered one-hot reduction over the cell row followed by the shift of the row.
// A stalled result holds the update until the output register frees.
// A restore request reloads the list, gives no result and never waits for the output register.
// Reset (rst_n low, synchronous): list in identity order, direction encode, output empty.
`default_nettype none

module move_to_front_byte_coder #(
  parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_MAX
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data,     // [0] direction
  // input requests
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire mtf_pkg::sym_t     in_tdata,     // [7:0] value
  input  wire logic              in_tuser,     // [0] action
  // results
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output mtf_pkg::sym_t          out_tdata     // [7:0] coded
);
  import mtf_pkg::*;

  localparam logic [SYM_W:0] SIZE_EXT = (SYM_W+1)'(ALPHABET_SIZE);
  localparam sym_t           MAX_SYM  = SYM_W'(ALPHABET_SIZE - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } state_t;

  state_t     state_r, state_nxt;
  logic       dir_r;
  sym_t       key_r, key_nxt;
  logic       out_valid_r, out_valid_nxt;
  sym_t       out_data_r, out_data_nxt;

  logic       in_acc;
  logic       out_free;
  sym_t       clamped;
  sym_t       red_pos;
  sym_t       red_sym;
  sym_t       front_sym;
  cell_ctrl_t ctrl;

  logic [ALPHABET_SIZE-1:0] hit;
  sym_t                     cell_sym [ALPHABET_SIZE];

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Saturate values beyond the alphabet
  assign clamped = ({1'b0, in_tdata} >= SIZE_EXT) ? MAX_SYM : in_tdata;

  // Encode: promote found position, front gets key. Decode: front gets found symbol.
  assign front_sym = dir_r ? red_sym : key_r;

  always_comb begin
    ctrl         = '0;
    ctrl.restore = in_acc && in_tuser;
    ctrl.commit  = (state_r == S_UPDATE) && out_free;
    ctrl.decode  = dir_r;
    ctrl.key     = key_r;
    ctrl.pos     = red_pos;
    ctrl.front   = front_sym;
  end

  // Row of list cells, each fed by its left neighbor
  for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
    mtf_cell #(
      .IDX(k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .left_sym ((k == 0) ? ctrl.front : cell_sym[(k == 0) ? 0 : k-1]),
      .sym      (cell_sym[k]),
      .hit      (hit[k])
    );
  end

  mtf_reduce #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_reduce (
    .clk   (clk),
    .hit   (hit),
    .sym   (cell_sym),
    .pos   (red_pos),
    .found (red_sym)
  );

  // Sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !in_tuser) begin
          key_nxt   = clamped;
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = dir_r ? red_sym : red_pos;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        dir_r <= cfg_data;
      end
    end
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/mtf_checker.sv
`default_nettype none
`include "assert_macros.svh"

module mtf_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_tvalid,
  input wire logic          in_tready,
  input wire logic          in_tuser,
  input wire logic          out_tvalid,
  input wire logic          out_tready,
  input wire mtf_pkg::sym_t out_tdata
);

  // Output register is empty right after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // A stalled result stays put
  `ASSERT_RST(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // A transform request closes the input until its result is produced
  `ASSERT_RST(a_busy, clk, rst_n, in_tvalid && in_tready && !in_tuser |=> !in_tready, "input open during transform")

  // A restore request produces no result
  `ASSERT_RST(a_restore_quiet, clk, rst_n, in_tvalid && in_tready && in_tuser && !out_tvalid |=> !out_tvalid, "restore produced a result")

endmodule

bind move_to_front_byte_coder mtf_checker u_mtf_checker (.*);

`default_nettype wire

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mtf_pkg::*;

  typedef enum logic {ACT_CODE = 1'b0, ACT_RESTORE = 1'b1} action_e;
  typedef enum logic {DIR_ENCODE = 1'b0, DIR_DECODE = 1'b1} direction_e;

  localparam int ALPHA          = mtf_pkg::ALPHABET_MAX;
  localparam int RAND_ITEMS     = 1930;
  localparam int RAND_PHASES    = 4;
  localparam int QUIET_ITEMS    = 250;
  localparam int HOLD_CYCLES    = 64;
  localparam int SETTLE_CYCLES  = 8;
  localparam int STALL_LIMIT    = 2000;
  localparam int N_ROWS         = 20;

  // one directed row: mode, request, and the coded value when it is obvious
  typedef struct packed {
    direction_e dir;
    action_e    act;
    sym_t       val;
    logic       known;
    sym_t       coded;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;
  logic       in_tvalid;
  logic       in_tready;
  sym_t       in_tdata;
  logic       in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  sym_t       out_tdata;

  move_to_front_byte_coder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),     // [0] direction
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // [7:0] value
    .in_tuser   (in_tuser),     // [0] action
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)     // [7:0] coded
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow list and mode
  sym_t       mtf_list [ALPHA];
  direction_e mtf_dir;
  sym_t       coded_q [$];

  int  fails;
  int  n_requests;
  int  n_restores;
  int  n_results;
  int  n_cfg_writes;
  int  n_encoded;
  int  n_decoded;
  bit  quiet_tail;
  bit  hold_req;
  bit  hold_busy;

  stim_row_t stim_tab [N_ROWS] = '{
    // encode from identity order
    '{DIR_ENCODE, ACT_CODE,    8'h00, 1'b1, 8'h00},
    '{DIR_ENCODE, ACT_CODE,    8'hFF, 1'b1, 8'hFF},
    '{DIR_ENCODE, ACT_CODE,    8'hFF, 1'b1, 8'h00},
    '{DIR_ENCODE, ACT_CODE,    8'h00, 1'b1, 8'h01},
    '{DIR_ENCODE, ACT_CODE,    8'h01, 1'b1, 8'h02},
    '{DIR_ENCODE, ACT_RESTORE, 8'hFF, 1'b0, 8'h00},
    '{DIR_ENCODE, ACT_CODE,    8'h80, 1'b1, 8'h80},
    '{DIR_ENCODE, ACT_CODE,    8'hAA, 1'b0, 8'h00},
    '{DIR_ENCODE, ACT_CODE,    8'h55, 1'b0, 8'h00},
    '{DIR_ENCODE, ACT_RESTORE, 8'h00, 1'b0, 8'h00},
    // decode, list back in identity order
    '{DIR_DECODE, ACT_CODE,    8'h00, 1'b1, 8'h00},
    '{DIR_DECODE, ACT_CODE,    8'hFF, 1'b1, 8'hFF},
    '{DIR_DECODE, ACT_CODE,    8'h00, 1'b1, 8'hFF},
    '{DIR_DECODE, ACT_CODE,    8'hFF, 1'b1, 8'hFE},
    '{DIR_DECODE, ACT_RESTORE, 8'hA5, 1'b0, 8'h00},
    '{DIR_DECODE, ACT_CODE,    8'hAA, 1'b1, 8'hAA},
    '{DIR_DECODE, ACT_CODE,    8'h55, 1'b0, 8'h00},
    '{DIR_DECODE, ACT_CODE,    8'h01, 1'b0, 8'h00},
    // restore keeps decode mode
    '{DIR_DECODE, ACT_RESTORE, 8'h5A, 1'b0, 8'h00},
    '{DIR_DECODE, ACT_CODE,    8'h00, 1'b1, 8'h00}
  };

  // move-to-front step on the shadow list; returns 1 when a result comes out
  function automatic bit mtf_step(action_e act, sym_t val, output sym_t coded);
    int   pos;
    int   v;
    sym_t sym;
    coded = '0;
    if (act == ACT_RESTORE) begin
      for (int i = 0; i < ALPHA; i++) mtf_list[i] = sym_t'(i);
      return 1'b0;
    end
    v = (int'(val) >= ALPHA) ? ALPHA - 1 : int'(val);
    pos = 0;
    if (mtf_dir == DIR_ENCODE) begin
      for (int i = 0; i < ALPHA; i++) begin
        if (mtf_list[i] == sym_t'(v)) begin
          pos = i;
          break;
        end
      end
    end else begin
      pos = v;
    end
    sym = mtf_list[pos];
    for (int k = pos; k > 0; k--) mtf_list[k] = mtf_list[k-1];
    mtf_list[0] = sym;
    coded = (mtf_dir == DIR_ENCODE) ? sym_t'(pos) : sym;
    return 1'b1;
  endfunction

  task automatic note_fail(input string msg);
    fails++;
    if (fails <= 10) $display("mismatch: %s", msg);
  endtask

  // offer one request and wait for it to be taken
  task automatic send_request(input action_e act, input sym_t val,
                              input logic known, input sym_t typed);
    sym_t pred;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_requests++;
    if (mtf_step(act, val, pred)) begin
      coded_q.insert(coded_q.size(), known ? typed : pred);
      if (mtf_dir == DIR_ENCODE) n_encoded++;
      else n_decoded++;
    end else begin
      n_restores++;
    end
  endtask

  // random idle burst on the request side
  task automatic pace_requests();
    if (!quiet_tail && !hold_busy && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // drain, let any restore settle, then write the mode
  task automatic set_direction(input direction_e d);
    in_tvalid <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mtf_dir = d;
    n_cfg_writes++;
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    sym_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (coded_q.size() == 0) begin
        note_fail($sformatf("result 0x%02h with nothing expected", out_tdata));
      end else begin
        want = coded_q.pop_front();
        if (out_tdata !== want)
          note_fail($sformatf("coded expected 0x%02h got 0x%02h", want, out_tdata));
      end
    end
  end

  // result-side backpressure: random stalls, one long hold on request
  initial begin : result_ready
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_busy = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin : stall_watch
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results pending",
                 idle_cycles, coded_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // main sequence
  initial begin : stimulus
    sym_t       hot [8];
    sym_t       v;
    int         r;
    int         sent;
    int         per_phase;
    direction_e ph_dir;

    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    for (int i = 0; i < ALPHA; i++) mtf_list[i] = sym_t'(i);
    mtf_dir = DIR_ENCODE;
    for (int i = 0; i < 8; i++) hot[i] = sym_t'($urandom_range(0, 255));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // explicit write of the reset value
    set_direction(DIR_ENCODE);

    // directed table
    for (int i = 0; i < N_ROWS; i++) begin
      if (stim_tab[i].dir != mtf_dir) set_direction(stim_tab[i].dir);
      send_request(stim_tab[i].act, stim_tab[i].val, stim_tab[i].known,
                   stim_tab[i].coded);
      pace_requests();
    end

    // random phases, alternating mode
    sent = 0;
    per_phase = RAND_ITEMS / RAND_PHASES;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      ph_dir = (ph % 2 == 0) ? DIR_ENCODE : DIR_DECODE;
      set_direction(ph_dir);
      for (int n = 0; n < per_phase; n++) begin
        if (sent >= RAND_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
        // long receiver hold while requests keep coming
        if (n == 100 && ph < RAND_PHASES - 1) begin
          hold_busy = 1'b1;
          hold_req  = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
          send_request(ACT_RESTORE, sym_t'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
          if (r < 40)
            v = (ph_dir == DIR_ENCODE) ? hot[$urandom_range(0, 7)]
                                       : sym_t'($urandom_range(0, 7));
          else if (r < 48)
            v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          else if (r < 60)
            v = sym_t'($urandom_range(0, 15));
          else
            v = sym_t'($urandom_range(0, 255));
          send_request(ACT_CODE, v, 1'b0, '0);
        end
        // let the working set drift
        if ($urandom_range(0, 15) == 0)
          hot[$urandom_range(0, 7)] = sym_t'($urandom_range(0, 255));
        sent++;
        pace_requests();
      end
    end
    in_tvalid <= 1'b0;

    // drain, then watch for stray results
    while (coded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (coded_q.size() != 0)
      note_fail($sformatf("%0d results never arrived", coded_q.size()));

    $display("run: %0d requests (%0d restores), %0d encoded, %0d decoded, %0d mode writes",
             n_requests, n_restores, n_encoded, n_decoded, n_cfg_writes);
    $display("run: %0d results checked, %0d failures", n_results, fails);
    if (fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/mtf_pkg.sv
rtl/core/mtf_cell.sv
rtl/core/mtf_reduce.sv
rtl/core/move_to_front_byte_coder.sv
rtl/core/mtf_checker.sv
dv/tb_top.sv
